FILE: src/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// Types, constants and helpers shared by the random generator block.
// ----------------------------------------------------------------------------
package lcg_pkg;

   localparam logic [31:0] LCG_MUL     = 32'hff1c_d035;
   localparam logic [63:0] LCG_ADD     = 64'd5;
   localparam int          FLOAT_SHIFT = 32 - 24;
   localparam logic [7:0]  EXP_BIAS    = 8'd103;

   localparam logic [1:0] FUNC_RESEED  = 2'd0;
   localparam logic [1:0] FUNC_RAW     = 2'd1;
   localparam logic [1:0] FUNC_BOUNDED = 2'd2;
   localparam logic [1:0] FUNC_FLOAT   = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] bound;
      logic        load_en;
      logic [63:0] load_val;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCALE,
      ST_DONE
   } back_state_type;

   // IEEE single pattern of x * 2^-24 for x below 2^24 (always exact)
   function automatic logic [31:0] unit_float_bits(input logic [23:0] x);
      logic [4:0]  msb;
      logic [23:0] sh;
      msb = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (x[i]) begin
            msb = 5'(i);
         end
      end
      sh = x << (5'd23 - msb);
      if (x == 24'd0) begin
         unit_float_bits = 32'd0;
      end else begin
         unit_float_bits = {1'b0, EXP_BIAS + {3'd0, msb}, sh[22:0]};
      end
   endfunction

endpackage

FILE: src/lcg_if.sv
// ----------------------------------------------------------------------------
// lcg_req_if / lcg_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface lcg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] bound;
   modport source (output valid, output func, output bound, input ready);
   modport sink   (input valid, input func, input bound, output ready);
endinterface

interface lcg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

FILE: src/lcg_front.sv
// ----------------------------------------------------------------------------
// lcg_front
// Accepts requests, resolves the seed source and queues work for the back.
// ----------------------------------------------------------------------------
module lcg_front (
   input  logic                  clock,
   input  logic                  reset,
   lcg_req_if.sink               req,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,
   input  logic                  pop,
   output lcg_pkg::queue_out_type q_out
);
   import lcg_pkg::*;

   logic [63:0] seed_ff;
   logic [63:0] tick_ff;
   logic        seeded_ff;
   entry_type   q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff;
   logic        push;
   entry_type   new_entry;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;

   always_comb begin
      new_entry.func  = req.func;
      new_entry.bound = req.bound;
      if (req.func == FUNC_RESEED) begin
         new_entry.load_en  = 1'b1;
         new_entry.load_val = (seed_ff != 64'd0) ? seed_ff : tick_ff;
      end else begin
         new_entry.load_en  = !seeded_ff;
         new_entry.load_val = tick_ff;
      end
   end

   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.entry = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= 64'd0;
         tick_ff   <= 64'd0;
         seeded_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         // advance the tick on every accepted beat
         if (push) begin
            tick_ff          <= tick_ff + 64'd1;
            seeded_ff        <= 1'b1;
            q_ff[wr_ptr_ff]  <= new_entry;
            wr_ptr_ff        <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

FILE: src/lcg_back.sv
// ----------------------------------------------------------------------------
// lcg_back
// Advances the generator state and scales the raw word into a result.
// ----------------------------------------------------------------------------
module lcg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  lcg_pkg::queue_out_type q_in,
   output logic                  pop,
   lcg_rsp_if.source             rsp
);
   import lcg_pkg::*;

   back_state_type state_ff, state_in;
   logic [63:0] gen_ff, gen_in;
   logic [63:0] plo_ff, plo_in;
   logic [31:0] phi_ff, phi_in;
   logic [31:0] raw_ff, raw_in;
   logic [63:0] prod_ff, prod_in;
   logic [1:0]  func_ff, func_in;
   logic [31:0] bound_ff, bound_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_ff, out_in;
   logic [63:0] st;
   logic [63:0] phi_full;
   logic [63:0] sum;

   assign rsp.valid = out_valid_ff;
   assign rsp.value = out_ff;

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      func_in      = func_ff;
      bound_in     = bound_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      pop          = 1'b0;
      st           = q_in.entry.load_en ? q_in.entry.load_val : gen_ff;
      phi_full     = st[63:32] * LCG_MUL;
      sum          = plo_ff + {phi_ff, 32'd0} + LCG_ADD;
      case (state_ff)
         ST_IDLE: begin
            if (q_in.valid) begin
               pop      = 1'b1;
               gen_in   = st;
               func_in  = q_in.entry.func;
               bound_in = q_in.entry.bound;
               plo_in   = st[31:0] * LCG_MUL;
               phi_in   = phi_full[31:0];
               if (q_in.entry.func != FUNC_RESEED) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            gen_in   = sum;
            raw_in   = sum[63:32];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = raw_ff * bound_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold while the previous result is still waiting
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               case (func_ff)
                  FUNC_BOUNDED: out_in = prod_ff[63:32];
                  FUNC_FLOAT:   out_in = unit_float_bits(raw_ff[31:FLOAT_SHIFT]);
                  default:      out_in = raw_ff;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      raw_ff   <= raw_in;
      prod_ff  <= prod_in;
      func_ff  <= func_in;
      bound_ff <= bound_in;
      out_ff   <= out_in;
   end
endmodule

FILE: src/lcg_random_generator_core.sv
// ----------------------------------------------------------------------------
// lcg_random_generator_core
// 64-bit linear congruential generator with raw, bounded and float draws.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | func[1:0], bound[31:0]
//  rsp     | out | valid/ready        | value[31:0]
//  csr     | in  | csr_wr_en          | csr_wr_data[63:0] (seed)
//
//  A reseed retires in the idle state; a draw steps through the back in
//  order (split 64x32 multiply, add, scaling multiply, result register).
//  A two-beat queue lets requests be taken while a draw is in flight.
//  The tick counter advances once per accepted request beat.
//  Reset is synchronous and clears control state; a stalled result holds.
module lcg_random_generator_core (
   input  logic        clock,
   input  logic        reset,
   lcg_req_if.sink     req,
   lcg_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);
   import lcg_pkg::*;

   queue_out_type q;
   logic          pop;

   lcg_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .pop(pop), .q_out(q)
   );

   lcg_back u_back (
      .clock(clock), .reset(reset), .q_in(q), .pop(pop), .rsp(rsp)
   );
endmodule

FILE: src/lcg_checker.sv
// ----------------------------------------------------------------------------
// lcg_checker
// Port-level checks on the random generator, bound to the top level.
// ----------------------------------------------------------------------------
module lcg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(rsp_valid, 1) == 1'b0 && !$past(reset, 4))
      else $error("result appeared too soon after reset");
endmodule

bind lcg_random_generator_core lcg_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.value)
);
